// ===== hdl/flow_flag_table_top_macros.svh =====
// Assertion helpers for the flow flag table
`ifndef FLOW_FLAG_TABLE_TOP_MACROS_SVH
`define FLOW_FLAG_TABLE_TOP_MACROS_SVH
// concurrent check, disabled in reset
`define FFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// concurrent check, active during reset too
`define FFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

// ===== hdl/fft_pkg.sv =====
// ----------------------------------------------------------------------------
// fft_pkg
// Shared types and constants of the flow flag table.
// ----------------------------------------------------------------------------
`default_nettype none
package fft_pkg;
    localparam int unsigned TableEntriesDef = 256;
    localparam int unsigned CountW = 9;
    localparam logic [CountW-1:0] CountMax = '1;

    localparam logic [1:0] KindSet      = 2'd0;
    localparam logic [1:0] KindUnset    = 2'd1;
    localparam logic [1:0] KindIsset    = 2'd2;
    localparam logic [1:0] KindIsnotset = 2'd3;

    localparam logic [2:0] DirNone    = 3'd0;
    localparam logic [2:0] DirBoth    = 3'd1;
    localparam logic [2:0] DirBySrc   = 3'd2;
    localparam logic [2:0] DirByDst   = 3'd3;
    localparam logic [2:0] DirReverse = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  direction;
        logic [15:0] flag_id;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] now_seconds;
        logic [23:0] timeout_seconds;
    } t_op;

    typedef struct packed {
        logic [CountW-1:0] match_count;
        logic              name_found;
        logic              created;
        logic              table_full;
    } t_res;
endpackage
`default_nettype wire

// ===== hdl/fft_front.sv =====
// ----------------------------------------------------------------------------
// fft_front
// Two-entry operation queue between the input port and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none
module fft_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  fft_pkg::t_op  i_op,
    output logic          o_full,
    output logic          o_valid,
    output fft_pkg::t_op  o_op,
    input  wire           i_take
);
    fft_pkg::t_op r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/fft_engine.sv =====
// ----------------------------------------------------------------------------
// fft_engine
// Scans the used entries one at a time: expiry, match, update, then append.
// ----------------------------------------------------------------------------
`default_nettype none
module fft_engine #(
    parameter int unsigned TABLE_ENTRIES = fft_pkg::TableEntriesDef
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  fft_pkg::t_op  i_op,
    output logic          o_take,
    output logic          o_res_valid,
    output fft_pkg::t_res o_res,
    input  wire           i_res_pop
);
    localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
    localparam int unsigned UsedW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [UsedW-1:0] UsedFull = UsedW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_DONE} t_state;
    typedef struct packed {
        logic [15:0] flag;
        logic [31:0] src;
        logic [31:0] dst;
        logic [32:0] expiry;
    } t_entry;

    t_entry r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_active;
    t_state r_state;
    fft_pkg::t_op r_op;
    t_entry r_rd;
    logic [UsedW-1:0] r_used, r_idx;
    logic [fft_pkg::CountW-1:0] r_count;
    logic r_found, r_res_valid;
    fft_pkg::t_res r_res;

    logic [IdxW-1:0] w_ix;
    logic [32:0] w_exp_new;
    logic w_act, w_id, w_addr, w_hit, w_wr;
    logic w_act_next, w_go, w_append, w_tbl_full;
    t_entry w_wdata;
    logic [IdxW-1:0] w_waddr;

    assign w_ix      = r_idx[IdxW-1:0];
    assign w_exp_new = {1'b0, r_op.now_seconds} + {9'd0, r_op.timeout_seconds};
    assign w_act     = r_active[w_ix] && ({1'b0, r_op.now_seconds} < r_rd.expiry);
    assign w_id      = (r_rd.flag == r_op.flag_id);
    assign o_take    = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res     = r_res;
    // closing cycle waits while the previous result is still held
    assign w_go       = !r_res_valid || i_res_pop;
    assign w_append   = (r_op.kind == fft_pkg::KindSet) && (r_count == '0) &&
                        (r_used != UsedFull);
    assign w_tbl_full = (r_op.kind == fft_pkg::KindSet) && (r_count == '0) &&
                        (r_used == UsedFull);

    always_comb begin
        unique case (r_op.direction)
            fft_pkg::DirNone:    w_addr = 1'b1;
            fft_pkg::DirBoth:    w_addr = r_rd.src == r_op.src_addr &&
                                          r_rd.dst == r_op.dst_addr;
            fft_pkg::DirBySrc:   w_addr = r_rd.src == r_op.src_addr;
            fft_pkg::DirByDst:   w_addr = r_rd.dst == r_op.dst_addr;
            fft_pkg::DirReverse: w_addr = r_rd.src == r_op.dst_addr &&
                                          r_rd.dst == r_op.src_addr;
            default:             w_addr = 1'b0;
        endcase
        unique case (r_op.kind)
            fft_pkg::KindSet:   w_hit = w_id && r_rd.src == r_op.src_addr &&
                                        r_rd.dst == r_op.dst_addr;
            fft_pkg::KindUnset: w_hit = w_id && w_addr;
            fft_pkg::KindIsset: w_hit = w_id && w_addr && w_act;
            default:            w_hit = w_id && w_addr && !w_act;
        endcase
        w_act_next = w_act;
        if (w_hit && r_op.kind == fft_pkg::KindSet) w_act_next = 1'b1;
        if (w_hit && r_op.kind == fft_pkg::KindUnset) w_act_next = 1'b0;
    end

    // one write port: refresh during scan, append at the end
    always_comb begin
        w_wdata = r_rd;
        w_wdata.expiry = w_exp_new;
        w_waddr = w_ix;
        w_wr = 1'b0;
        if (r_state == S_EVAL && r_op.kind == fft_pkg::KindSet && w_hit) begin
            w_wr = 1'b1;
        end else if (r_state == S_DONE && w_go && w_append) begin
            w_wr = 1'b1;
            w_waddr = r_used[IdxW-1:0];
            w_wdata = '{flag: r_op.flag_id, src: r_op.src_addr,
                        dst: r_op.dst_addr, expiry: w_exp_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_ix];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_used      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_go) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_idx   <= '0;
                        r_count <= '0;
                        r_found <= 1'b0;
                        r_state <= (r_used == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    r_active[w_ix] <= w_act_next;
                    if (w_id) r_found <= 1'b1;
                    if (w_hit && r_count != fft_pkg::CountMax) r_count <= r_count + 1'b1;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (r_idx + 1'b1 == r_used) ? S_DONE : S_READ;
                end
                S_DONE: begin
                    if (w_go) begin
                        r_res.match_count <= r_count;
                        r_res.name_found  <= r_found;
                        r_res.created     <= w_append;
                        r_res.table_full  <= w_tbl_full;
                        if (w_append) begin
                            r_active[r_used[IdxW-1:0]] <= 1'b1;
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/flow_flag_table_top.sv =====
// Flow flag table. Operations enter a two-deep queue; the engine takes one at
// a time, reads each used entry (memory read, then expire, match and refresh)
// and closes with append and result. The run time of an operation is set by
// the serial walk of the entry memory. Results wait in an output register;
// the engine may start the next operation while a result waits, and holds in
// its closing cycle until that result is popped.
// ----------------------------------------------------------------------------
// flow_flag_table_top
// Top level: input queue, table engine, result port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flow_flag_table_top_macros.svh"
module flow_flag_table_top #(
    parameter int unsigned TABLE_ENTRIES = fft_pkg::TableEntriesDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [1:0]  i_kind,
    input  wire  [2:0]  i_direction,
    input  wire  [15:0] i_flag_id,
    input  wire  [31:0] i_src_addr,
    input  wire  [31:0] i_dst_addr,
    input  wire  [31:0] i_now_seconds,
    input  wire  [23:0] i_timeout_seconds,
    output logic        empty,
    input  wire         pop,
    output logic [8:0]  o_match_count,
    output logic        o_name_found,
    output logic        o_created,
    output logic        o_table_full
);
    fft_pkg::t_op  w_in_op, w_q_op;
    fft_pkg::t_res w_res;
    logic w_q_valid, w_take, w_res_valid;

    assign w_in_op = '{kind: i_kind, direction: i_direction, flag_id: i_flag_id,
                       src_addr: i_src_addr, dst_addr: i_dst_addr,
                       now_seconds: i_now_seconds,
                       timeout_seconds: i_timeout_seconds};

    fft_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_op(w_in_op), .o_full(full),
        .o_valid(w_q_valid), .o_op(w_q_op), .i_take(w_take)
    );

    fft_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
        .i_clk, .i_rst_n, .i_valid(w_q_valid), .i_op(w_q_op), .o_take(w_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_pop(pop)
    );

    assign empty         = !w_res_valid;
    assign o_match_count = w_res.match_count;
    assign o_name_found  = w_res.name_found;
    assign o_created     = w_res.created;
    assign o_table_full  = w_res.table_full;

    `FFT_ASSERT(a_created_excl, !empty |-> !(o_created && o_table_full), "created and full")
    `FFT_ASSERT(a_created_zero, !empty && o_created |-> o_match_count == '0, "created with hits")
    `FFT_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(o_match_count), "result dropped")
    `FFT_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> empty, "result after reset")
endmodule
`default_nettype wire

// ===== verif/flow_flag_table_checker.sv =====
// ----------------------------------------------------------------------------
// flow_flag_table_checker
// Watches both queue ports of the flow flag table. It keeps its own copy of the
// table, works out the result of every accepted operation and compares it,
// field by field, with each popped result.
// ----------------------------------------------------------------------------
module flow_flag_table_checker #(
    parameter int unsigned ENTRIES = fft_pkg::TableEntriesDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire         i_full,
    input  wire  [1:0]  i_kind,
    input  wire  [2:0]  i_direction,
    input  wire  [15:0] i_flag_id,
    input  wire  [31:0] i_src_addr,
    input  wire  [31:0] i_dst_addr,
    input  wire  [31:0] i_now_seconds,
    input  wire  [23:0] i_timeout_seconds,
    input  wire         i_empty,
    input  wire         i_pop,
    input  wire  [8:0]  i_match_count,
    input  wire         i_name_found,
    input  wire         i_created,
    input  wire         i_table_full,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] flag_mem [ENTRIES];
    logic [31:0] src_mem [ENTRIES];
    logic [31:0] dst_mem [ENTRIES];
    logic [32:0] expiry_mem [ENTRIES];
    logic        active_mem [ENTRIES];
    int unsigned used_cnt;

    fft_pkg::t_res expected_results[$];

    initial begin
        o_fail_count = 0;
        used_cnt = 0;
        for (int i = 0; i < ENTRIES; i++) active_mem[i] = 1'b0;
    end

    assign o_pending = expected_results.size();

    function automatic logic dir_hit(logic [2:0] dir, int idx, logic [31:0] s,
                                     logic [31:0] d);
        case (dir)
            fft_pkg::DirNone:    return 1'b1;
            fft_pkg::DirBoth:    return src_mem[idx] == s && dst_mem[idx] == d;
            fft_pkg::DirBySrc:   return src_mem[idx] == s;
            fft_pkg::DirByDst:   return dst_mem[idx] == d;
            fft_pkg::DirReverse: return src_mem[idx] == d && dst_mem[idx] == s;
            default:             return 1'b0;
        endcase
    endfunction

    task automatic apply_op(fft_pkg::t_op op);
        fft_pkg::t_res r;
        logic hit;
        logic [32:0] exp_time;
        r = '0;
        exp_time = {1'b0, op.now_seconds} + {9'd0, op.timeout_seconds};
        for (int i = 0; i < used_cnt; i++) begin
            if (active_mem[i] && {1'b0, op.now_seconds} >= expiry_mem[i]) active_mem[i] = 1'b0;
            if (flag_mem[i] == op.flag_id) r.name_found = 1'b1;
        end
        for (int i = 0; i < used_cnt; i++) begin
            hit = 1'b0;
            if (flag_mem[i] == op.flag_id) begin
                if (op.kind == fft_pkg::KindSet) begin
                    if (src_mem[i] == op.src_addr && dst_mem[i] == op.dst_addr) begin
                        expiry_mem[i] = exp_time;
                        active_mem[i] = 1'b1;
                        hit = 1'b1;
                    end
                end else if (dir_hit(op.direction, i, op.src_addr, op.dst_addr)) begin
                    if (op.kind == fft_pkg::KindUnset) begin
                        active_mem[i] = 1'b0;
                        hit = 1'b1;
                    end else if (op.kind == fft_pkg::KindIsset) begin
                        hit = active_mem[i];
                    end else begin
                        hit = !active_mem[i];
                    end
                end
            end
            if (hit && r.match_count != fft_pkg::CountMax) r.match_count++;
        end
        if (op.kind == fft_pkg::KindSet && r.match_count == 0) begin
            if (used_cnt < ENTRIES) begin
                flag_mem[used_cnt] = op.flag_id;
                src_mem[used_cnt] = op.src_addr;
                dst_mem[used_cnt] = op.dst_addr;
                expiry_mem[used_cnt] = exp_time;
                active_mem[used_cnt] = 1'b1;
                used_cnt++;
                r.created = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        fft_pkg::t_res want;
        fft_pkg::t_res got;
        if (i_rst_n) begin
            if (i_push && !i_full)
                apply_op('{i_kind, i_direction, i_flag_id, i_src_addr, i_dst_addr,
                           i_now_seconds, i_timeout_seconds});
            if (i_pop && !i_empty) begin
                got = '{i_match_count, i_name_found, i_created, i_table_full};
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", got);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/flow_flag_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// flow_flag_table_top_tb
// Drives directed and random flag operations through the table under several
// idle and stall patterns, a long output hold-off and a table fill; the
// checker predicts and compares each result beat.
// ----------------------------------------------------------------------------
module flow_flag_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 6000000;
    localparam int unsigned RandomOps = 1600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = '0;
    logic [2:0]  i_direction = '0;
    logic [15:0] i_flag_id = '0;
    logic [31:0] i_src_addr = '0;
    logic [31:0] i_dst_addr = '0;
    logic [31:0] i_now_seconds = '0;
    logic [23:0] i_timeout_seconds = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [8:0]  o_match_count;
    logic        o_name_found;
    logic        o_created;
    logic        o_table_full;

    int fail_count;
    int pending;
    int unsigned cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_pop = 1'b0;
    logic [31:0] clock_s = 32'd100;

    flow_flag_table_top DUT (.*);

    flow_flag_table_checker u_checker (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full), .i_kind, .i_direction, .i_flag_id,
        .i_src_addr, .i_dst_addr, .i_now_seconds, .i_timeout_seconds, .i_empty(empty),
        .i_pop(pop), .i_match_count(o_match_count), .i_name_found(o_name_found),
        .i_created(o_created), .i_table_full(o_table_full),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("flow_flag_table_top_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk)
        pop <= !hold_pop && ($urandom_range(99) >= recv_stall_pct);

    // one beat; push stays high into the next beat when there is no idle
    task automatic send_op(logic [1:0] k, logic [2:0] d, logic [15:0] id,
                           logic [31:0] s, logic [31:0] t, logic [31:0] now,
                           logic [23:0] tmo);
        logic f;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= k;
        i_direction <= d;
        i_flag_id <= id;
        i_src_addr <= s;
        i_dst_addr <= t;
        i_now_seconds <= now;
        i_timeout_seconds <= tmo;
        forever begin
            @(negedge i_clk);
            f = full;
            @(posedge i_clk);
            if (!f) break;
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    // small pools so operations hit each other; occasional wide values
    task automatic send_random();
        logic [15:0] id;
        logic [31:0] s, t, now;
        logic [23:0] tmo;
        logic [1:0] k;
        logic [2:0] d;
        k = 2'($urandom_range(3));
        d = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        id = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        s = ($urandom_range(15) == 0) ? $urandom : 32'hC0A8_0000 + $urandom_range(3);
        t = ($urandom_range(15) == 0) ? $urandom : 32'h0A00_0000 + $urandom_range(3);
        if ($urandom_range(3) == 0) begin
            s = t;
            t = 32'hC0A8_0000 + $urandom_range(3);
        end
        clock_s = clock_s + $urandom_range(3);
        now = ($urandom_range(31) == 0) ? $urandom : clock_s;
        case ($urandom_range(7))
            0:       tmo = 24'($urandom);
            1:       tmo = 24'hFF_FFFF;
            default: tmo = 24'($urandom_range(8));
        endcase
        send_op(k, d, id, s, t, now, tmo);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero lifetime, reverse match, odd directions
        send_op(fft_pkg::KindSet, fft_pkg::DirNone, 16'h0000, 32'h0, 32'h0, 32'h0, 24'h0);
        send_op(fft_pkg::KindIsset, fft_pkg::DirNone, 16'h0000, 32'h0, 32'h0, 32'h0, 24'h0);
        send_op(fft_pkg::KindIsnotset, fft_pkg::DirBoth, 16'h0000, 32'h0, 32'h0, 32'h0,
                24'h0);
        send_op(fft_pkg::KindSet, fft_pkg::DirBoth, 16'h0000, 32'h0, 32'h0, 32'h1, 24'h5);
        send_op(fft_pkg::KindSet, fft_pkg::DirNone, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 24'hFF_FFFF);
        send_op(fft_pkg::KindIsset, fft_pkg::DirBoth, 16'hFFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0);
        send_op(fft_pkg::KindSet, fft_pkg::DirNone, 16'h0005, 32'h0A00_0001, 32'h0A00_0002,
                32'd10, 24'd50);
        send_op(fft_pkg::KindIsset, fft_pkg::DirReverse, 16'h0005, 32'h0A00_0002,
                32'h0A00_0001, 32'd11, 24'd0);
        send_op(fft_pkg::KindIsset, fft_pkg::DirBySrc, 16'h0005, 32'h0A00_0001, 32'h0,
                32'd11, 24'd0);
        send_op(fft_pkg::KindIsset, fft_pkg::DirByDst, 16'h0005, 32'h0, 32'h0A00_0002,
                32'd11, 24'd0);
        for (int d = 5; d < 8; d++) begin
            send_op(fft_pkg::KindUnset, 3'(d), 16'h0005, 32'h0A00_0001, 32'h0A00_0002,
                    32'd12, 24'd0);
            send_op(fft_pkg::KindIsset, 3'(d), 16'h0005, 32'h0A00_0001, 32'h0A00_0002,
                    32'd12, 24'd0);
        end
        send_op(fft_pkg::KindUnset, fft_pkg::DirBoth, 16'h0005, 32'h0A00_0001,
                32'h0A00_0002, 32'd13, 24'd0);
        send_op(fft_pkg::KindIsnotset, fft_pkg::DirNone, 16'h0005, 32'h0, 32'h0, 32'd13,
                24'd0);
        send_op(fft_pkg::KindUnset, fft_pkg::DirNone, 16'h0005, 32'h0, 32'h0, 32'd13, 24'd0);
        send_op(fft_pkg::KindIsnotset, fft_pkg::DirNone, 16'h1234, 32'h0, 32'h0, 32'd13,
                24'd0);
        send_op(fft_pkg::KindSet, fft_pkg::DirNone, 16'h0005, 32'h0A00_0001, 32'h0A00_0002,
                32'd70, 24'd3);
        send_op(fft_pkg::KindIsset, fft_pkg::DirNone, 16'h0005, 32'h0, 32'h0, 32'd73, 24'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat (RandomOps / 4) send_random();
            drain();
        end

        // output hold-off long enough that the input queue fills behind it
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_pop <= 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_pop <= 1'b0;
            end
        join_none
        repeat (20) send_random();
        drain();

        // fill the table, then go past full
        send_idle_pct = 13;
        recv_stall_pct = 13;
        for (int i = 0; i < 270; i++)
            send_op(fft_pkg::KindSet, fft_pkg::DirNone, 16'hF000 + i[15:0],
                    32'hAC10_0000 + i, 32'h0B00_0000, clock_s, 24'd1000);
        send_op(fft_pkg::KindSet, fft_pkg::DirNone, 16'hF000, 32'hAC10_0000, 32'h0B00_0000,
                clock_s, 24'd9);
        send_op(fft_pkg::KindIsset, fft_pkg::DirBySrc, 16'hF001, 32'hAC10_0001, 32'h0,
                clock_s, 24'd0);
        send_op(fft_pkg::KindIsnotset, fft_pkg::DirNone, 16'hF00F, 32'h0, 32'h0,
                clock_s + 32'd2000, 24'd0);
        drain();

        if (fail_count == 0) begin
            $display("flow_flag_table_top_tb: PASS");
        end else begin
            $display("flow_flag_table_top_tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fft_pkg.sv
hdl/fft_front.sv
hdl/fft_engine.sv
hdl/flow_flag_table_top.sv
verif/flow_flag_table_checker.sv
verif/flow_flag_table_top_tb.sv
